// ===== src/rti_pkg.sv =====
package rti_pkg;

  localparam int unsigned IN_W      = 448;
  localparam int unsigned OUT_W     = 216;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned EDGE_W    = 33;
  localparam int unsigned PROD_W    = 66;
  localparam int unsigned CROSS_W   = 67;
  localparam int unsigned SPLIT_W   = 34;
  localparam int unsigned SUM_W     = 104;
  localparam int unsigned DIST_QW   = 31;
  localparam int unsigned BARY_QW   = 16;
  localparam int unsigned NORM_QW   = 15;
  localparam int unsigned NL_W      = 30;
  localparam int unsigned LEN2_W    = 62;
  localparam int unsigned ROOT_W    = 63;
  localparam int unsigned LEN_W     = 31;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned THR_W     = 16;

  typedef struct packed {
    logic        [16:0] bary_v;
    logic        [16:0] bary_u;
    logic signed [15:0] normal_z;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_x;
    logic signed [31:0] point_z;
    logic signed [31:0] point_y;
    logic signed [31:0] point_x;
    logic        [30:0] distance;
  } result_t;

endpackage

// ===== src/rti_div.sv =====
module rti_div #(
  parameter int unsigned DW = rti_pkg::SUM_W,
  parameter int unsigned QW = rti_pkg::DIST_QW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] low_in,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem [1:QW];
  logic [QW-1:0] low [1:QW];
  logic [DW-1:0] dv  [1:QW];
  logic [QW-1:0] qt  [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] r_src;
    logic [QW-1:0] l_src;
    logic [DW-1:0] d_src;
    logic [QW-1:0] q_src;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    if (k == 0) begin : g_src
      assign r_src = rem_in;
      assign l_src = low_in;
      assign d_src = den;
      assign q_src = '0;
    end else begin : g_src
      assign r_src = rem[k];
      assign l_src = low[k];
      assign d_src = dv[k];
      assign q_src = qt[k];
    end

    assign trial = {r_src, l_src[QW-1]};
    assign diff  = trial - {1'b0, d_src};
    assign take  = trial >= {1'b0, d_src};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? diff[DW-1:0] : trial[DW-1:0];
        low[k+1] <= l_src << 1;
        dv[k+1]  <= d_src;
        qt[k+1]  <= {q_src[QW-2:0], take};
      end
    end
  end

  assign quo = qt[QW];

endmodule

// ===== src/ray_triangle_intersect_unit.sv =====
// Front-face ray/triangle test, one test accepted per clock while s_tready is
// high. Each beat on the s side carries a ray and a triangle; exactly one
// result beat leaves on the m side per input beat, in order. The normal path
// is the longest: a 32-stage pipelined square root followed by a 15-stage
// pipelined divider; distance and barycentrics use 31- and 16-stage dividers
// that run alongside. A two-entry output register (output plus skid) lets one
// more beat in while a result waits; after that the whole pipe holds until
// the m side takes the result. det_threshold is written through the cfg
// channel, which is always ready; write it only while no test is in flight.
// A miss returns all fields as zero with hit low.
module ray_triangle_intersect_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // origin_x/y/z, dir_x/y/z, vert_a_x/y/z, vert_b_x/y/z, vert_c_packed
  input  logic [rti_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // distance, point_x/y/z, normal_x/y/z, bary_u, bary_v, zero pad
  output logic [rti_pkg::OUT_W-1:0] m_tdata,
  // hit
  output logic [0:0]                m_tuser,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rti_pkg::THR_W-1:0] cfg_data
);

  localparam int unsigned LAST = 57;
  localparam int J_IDX [3] = '{1, 2, 0};
  localparam int K_IDX [3] = '{2, 0, 1};

  logic [rti_pkg::THR_W-1:0] det_threshold;
  logic [LAST:1] vld;
  logic en;
  logic skid_v;
  logic up_valid;

  assign cfg_ready = 1'b1;
  assign en        = !skid_v;
  assign s_tready  = en;
  assign up_valid  = vld[LAST] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= rti_pkg::THR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      det_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:1], s_tvalid};
    end
  end

  // stage 1: unpack, edges
  logic signed [31:0] in_o [3], in_d [3], in_a [3], in_b [3], in_c [3];
  logic signed [31:0] o1 [3], d1 [3];
  logic signed [32:0] e1_1 [3], e2_1 [3], ao1 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_o[i] = s_tdata[32*i +: 32];
      in_d[i] = s_tdata[96 + 32*i +: 32];
      in_a[i] = s_tdata[192 + 32*i +: 32];
      in_c[i] = {{5{s_tdata[384 + 21*i + 20]}}, s_tdata[384 + 21*i +: 21], 6'd0};
    end
    in_b[0] = s_tdata[319:288];
    in_b[1] = s_tdata[351:320];
    in_b[2] = s_tdata[383:352];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        o1[i]   <= in_o[i];
        d1[i]   <= in_d[i];
        e1_1[i] <= {in_c[i][31], in_c[i]} - {in_a[i][31], in_a[i]};
        e2_1[i] <= {in_b[i][31], in_b[i]} - {in_a[i][31], in_a[i]};
        ao1[i]  <= {in_o[i][31], in_o[i]} - {in_a[i][31], in_a[i]};
      end
    end
  end

  // payload delay lines
  logic signed [31:0] d_dl [37][3];
  logic signed [31:0] o_dl [38][3];
  logic signed [32:0] e1_dl [2][3], e2_dl [2][3], ao_dl [2][3];

  always_ff @(posedge clk) begin
    if (en) begin
      d_dl[0]  <= d1;
      o_dl[0]  <= o1;
      e1_dl[0] <= e1_1;
      e2_dl[0] <= e2_1;
      ao_dl[0] <= ao1;
      e1_dl[1] <= e1_dl[0];
      e2_dl[1] <= e2_dl[0];
      ao_dl[1] <= ao_dl[0];
      for (int j = 1; j < 37; j++) d_dl[j] <= d_dl[j-1];
      for (int j = 1; j < 38; j++) o_dl[j] <= o_dl[j-1];
    end
  end

  // stage 2: cross products
  logic signed [rti_pkg::PROD_W-1:0] np_a [3], np_b [3], qp_a [3], qp_b [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        np_a[i] <= e1_1[J_IDX[i]] * e2_1[K_IDX[i]];
        np_b[i] <= e1_1[K_IDX[i]] * e2_1[J_IDX[i]];
        qp_a[i] <= ao1[J_IDX[i]] * $signed({d1[K_IDX[i]][31], d1[K_IDX[i]]});
        qp_b[i] <= ao1[K_IDX[i]] * $signed({d1[J_IDX[i]][31], d1[J_IDX[i]]});
      end
    end
  end

  // stage 3: normal and Q
  logic signed [rti_pkg::CROSS_W-1:0] n3 [3], q3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n3[i] <= {np_a[i][65], np_a[i]} - {np_b[i][65], np_b[i]};
        q3[i] <= {qp_a[i][65], qp_a[i]} - {qp_b[i][65], qp_b[i]};
      end
    end
  end

  // stage 4: split partial products of the four dot products
  logic signed [32:0] dx [4][3];
  logic signed [rti_pkg::CROSS_W-1:0] dy [4][3];
  logic signed [67:0] pl4 [4][3];
  logic signed [65:0] ph4 [4][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dx[0][i] = {d_dl[1][i][31], d_dl[1][i]};
      dy[0][i] = n3[i];
      dx[1][i] = ao_dl[1][i];
      dy[1][i] = n3[i];
      dx[2][i] = e2_dl[1][i];
      dy[2][i] = q3[i];
      dx[3][i] = e1_dl[1][i];
      dy[3][i] = q3[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          pl4[k][i] <= dx[k][i] * $signed({1'b0, dy[k][i][rti_pkg::SPLIT_W-1:0]});
          ph4[k][i] <= dx[k][i] * $signed(dy[k][i][rti_pkg::CROSS_W-1:rti_pkg::SPLIT_W]);
        end
      end
    end
  end

  // stage 5: recombine partials
  logic signed [rti_pkg::SUM_W-1:0] ph_x [4][3], pl_x [4][3], pr5 [4][3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        ph_x[k][i] = {{38{ph4[k][i][65]}}, ph4[k][i]};
        pl_x[k][i] = {{36{pl4[k][i][67]}}, pl4[k][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          pr5[k][i] <= (ph_x[k][i] <<< rti_pkg::SPLIT_W) + pl_x[k][i];
        end
      end
    end
  end

  // stage 6: det and numerators
  logic signed [rti_pkg::SUM_W-1:0] det6, tn6, un6, vn6;

  always_ff @(posedge clk) begin
    if (en) begin
      det6 <= -(pr5[0][0] + pr5[0][1] + pr5[0][2]);
      tn6  <= pr5[1][0] + pr5[1][1] + pr5[1][2];
      un6  <= pr5[2][0] + pr5[2][1] + pr5[2][2];
      vn6  <= -(pr5[3][0] + pr5[3][1] + pr5[3][2]);
    end
  end

  // stage 7: hit decision and saturation flags
  logic signed [rti_pkg::SUM_W-1:0] det7, tn7, un7, vn7;
  logic signed [rti_pkg::SUM_W-1:0] thr_w, tn_sh;
  logic signed [rti_pkg::SUM_W:0]   uv_sum;
  logic hit7, sat_t7, sat_u7, sat_v7;

  assign thr_w  = $signed({56'd0, det_threshold, 32'd0});
  assign tn_sh  = tn6 >>> 15;
  assign uv_sum = $signed({un6[103], un6}) + $signed({vn6[103], vn6});

  always_ff @(posedge clk) begin
    if (en) begin
      det7   <= det6;
      tn7    <= tn6;
      un7    <= un6;
      vn7    <= vn6;
      hit7   <= !det6[103] && (|det6) && (det6 >= thr_w) && !tn6[103] && !un6[103]
                && !vn6[103] && (uv_sum <= $signed({det6[103], det6}));
      sat_t7 <= tn_sh >= det6;
      sat_u7 <= un6 >= det6;
      sat_v7 <= vn6 >= det6;
    end
  end

  // dividers for distance and barycentrics
  logic [rti_pkg::DIST_QW-1:0] t_q;
  logic [rti_pkg::BARY_QW-1:0] u_q, v_q;
  logic [rti_pkg::SUM_W-1:0] tn_sh7;

  assign tn_sh7 = tn7 >>> 15;

  rti_div #(.DW(rti_pkg::SUM_W), .QW(rti_pkg::DIST_QW)) u_div_t (
    .clk(clk), .en(en), .rem_in(tn_sh7), .low_in({tn7[14:0], 16'd0}),
    .den(det7), .quo(t_q)
  );

  rti_div #(.DW(rti_pkg::SUM_W), .QW(rti_pkg::BARY_QW)) u_div_u (
    .clk(clk), .en(en), .rem_in(un7), .low_in('0), .den(det7), .quo(u_q)
  );

  rti_div #(.DW(rti_pkg::SUM_W), .QW(rti_pkg::BARY_QW)) u_div_v (
    .clk(clk), .en(en), .rem_in(vn7), .low_in('0), .den(det7), .quo(v_q)
  );

  logic hit_dl [49];
  logic sat_t_dl [31];
  logic sat_u_dl [16], sat_v_dl [16];
  logic [16:0] u23, v23;
  logic [16:0] u_dl [33], v_dl [33];

  assign u23 = sat_u_dl[15] ? 17'h10000 : {1'b0, u_q};
  assign v23 = sat_v_dl[15] ? 17'h10000 : {1'b0, v_q};

  always_ff @(posedge clk) begin
    if (en) begin
      hit_dl[0]   <= hit7;
      sat_t_dl[0] <= sat_t7;
      sat_u_dl[0] <= sat_u7;
      sat_v_dl[0] <= sat_v7;
      u_dl[0]     <= u23;
      v_dl[0]     <= v23;
      for (int j = 1; j < 49; j++) hit_dl[j] <= hit_dl[j-1];
      for (int j = 1; j < 31; j++) sat_t_dl[j] <= sat_t_dl[j-1];
      for (int j = 1; j < 16; j++) begin
        sat_u_dl[j] <= sat_u_dl[j-1];
        sat_v_dl[j] <= sat_v_dl[j-1];
      end
      for (int j = 1; j < 33; j++) begin
        u_dl[j] <= u_dl[j-1];
        v_dl[j] <= v_dl[j-1];
      end
    end
  end

  // stages 39 and 40: hit point
  logic [30:0] t38, dist39;
  logic signed [63:0] prod39 [3];
  logic signed [63:0] prod_sh [3];
  logic signed [48:0] pt_sum [3];
  logic signed [31:0] pt_sat [3];
  logic signed [31:0] pt40 [3];
  logic [30:0] dist_dl [17];
  logic signed [31:0] pt_dl [16][3];

  assign t38 = sat_t_dl[30] ? 31'h7FFF_FFFF : t_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_sh[i] = prod39[i] >>> 16;
      pt_sum[i]  = $signed({{17{o_dl[37][i][31]}}, o_dl[37][i]}) + $signed(prod_sh[i][48:0]);
      if (pt_sum[i][48] && !(&pt_sum[i][47:31])) begin
        pt_sat[i] = 32'sh8000_0000;
      end else if (!pt_sum[i][48] && (|pt_sum[i][47:31])) begin
        pt_sat[i] = 32'sh7FFF_FFFF;
      end else begin
        pt_sat[i] = pt_sum[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist39 <= t38;
      for (int i = 0; i < 3; i++) begin
        prod39[i] <= d_dl[36][i] * $signed({1'b0, t38});
        pt40[i]   <= pt_sat[i];
      end
      dist_dl[0] <= dist39;
      pt_dl[0]   <= pt40;
      for (int j = 1; j < 17; j++) dist_dl[j] <= dist_dl[j-1];
      for (int j = 1; j < 16; j++) pt_dl[j] <= pt_dl[j-1];
    end
  end

  // normal path: magnitudes, leading bit search, scale
  logic [2:0] neg_dl [53];
  logic [rti_pkg::CROSS_W-1:0] mag4 [3], or4;
  logic [rti_pkg::CROSS_W-1:0] mag_dl [2][3];
  logic [71:0] or_pad;
  logic [8:0] nz_c, nz5;
  logic [2:0] pos_c [9], pos5 [9];
  logic [6:0] bits_c, bits6;
  logic [rti_pkg::CROSS_W-1:0] shv [3];
  logic [rti_pkg::NL_W-1:0] nl7 [3];
  logic [59:0] sq8 [3];
  logic [rti_pkg::LEN2_W-1:0] len2_9;
  logic [rti_pkg::NL_W-1:0] nl_dl [34][3];

  assign or_pad = {5'd0, or4};

  always_comb begin
    for (int g = 0; g < 9; g++) begin
      nz_c[g]  = |or_pad[8*g +: 8];
      pos_c[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (or_pad[8*g + b]) pos_c[g] = 3'(b);
      end
    end
    bits_c = 7'd0;
    for (int g = 0; g < 9; g++) begin
      if (nz5[g]) bits_c = 7'(8*g) + {4'd0, pos5[g]} + 7'd1;
    end
    for (int i = 0; i < 3; i++) begin
      if (bits6 > 7'd30) begin
        shv[i] = mag_dl[1][i] >> (bits6 - 7'd30);
      end else begin
        shv[i] = mag_dl[1][i] << (7'd30 - bits6);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag4[i] <= n3[i][66] ? -n3[i] : n3[i];
      end
      or4 <= (n3[0][66] ? -n3[0] : n3[0]) | (n3[1][66] ? -n3[1] : n3[1])
           | (n3[2][66] ? -n3[2] : n3[2]);
      mag_dl[0] <= mag4;
      mag_dl[1] <= mag_dl[0];
      nz5   <= nz_c;
      pos5  <= pos_c;
      bits6 <= bits_c;
      for (int i = 0; i < 3; i++) begin
        nl7[i] <= shv[i][rti_pkg::NL_W-1:0];
        sq8[i] <= nl7[i] * nl7[i];
      end
      len2_9 <= {2'd0, sq8[0]} + {2'd0, sq8[1]} + {2'd0, sq8[2]};
      neg_dl[0] <= {n3[2][66], n3[1][66], n3[0][66]};
      for (int j = 1; j < 53; j++) neg_dl[j] <= neg_dl[j-1];
      nl_dl[0] <= nl7;
      for (int j = 1; j < 34; j++) nl_dl[j] <= nl_dl[j-1];
    end
  end

  // square root, one result bit per stage
  logic [rti_pkg::ROOT_W-1:0] sq_x [1:rti_pkg::ROOT_STEPS];
  logic [rti_pkg::ROOT_W-1:0] sq_r [1:rti_pkg::ROOT_STEPS];

  for (genvar j = 0; j < rti_pkg::ROOT_STEPS; j++) begin : g_root
    localparam logic [rti_pkg::ROOT_W-1:0] SQ_BIT =
      rti_pkg::ROOT_W'(1) << (rti_pkg::ROOT_W - 1 - 2*j);
    logic [rti_pkg::ROOT_W-1:0] x_src, r_src, trial;
    logic take;

    if (j == 0) begin : g_src
      assign x_src = {1'b0, len2_9};
      assign r_src = '0;
    end else begin : g_src
      assign x_src = sq_x[j];
      assign r_src = sq_r[j];
    end

    assign trial = r_src + SQ_BIT;
    assign take  = x_src >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_x[j+1] <= take ? x_src - trial : x_src;
        sq_r[j+1] <= take ? (r_src >> 1) + SQ_BIT : r_src >> 1;
      end
    end
  end

  logic [rti_pkg::LEN_W-1:0] len41;
  logic [rti_pkg::NORM_QW-1:0] nq [3];

  assign len41 = sq_r[rti_pkg::ROOT_STEPS][rti_pkg::LEN_W-1:0];

  for (genvar i = 0; i < 3; i++) begin : g_norm
    rti_div #(.DW(rti_pkg::LEN_W), .QW(rti_pkg::NORM_QW)) u_div_n (
      .clk(clk), .en(en),
      .rem_in({2'd0, nl_dl[33][i][rti_pkg::NL_W-1:1]}),
      .low_in({nl_dl[33][i][0], 14'd0}),
      .den(len41), .quo(nq[i])
    );
  end

  // stage 57: assemble, zero on miss
  rti_pkg::result_t res57, res_c, out_data, skid_data;
  logic hit57, out_hit, skid_hit;
  logic [15:0] nmag [3];
  logic signed [15:0] nval [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag[i] = (nq[i] > 15'd16384) ? 16'd16384 : {1'b0, nq[i]};
      nval[i] = neg_dl[52][i] ? -$signed(nmag[i]) : $signed(nmag[i]);
    end
    res_c          = '0;
    if (hit_dl[48]) begin
      res_c.distance = dist_dl[16];
      res_c.point_x  = pt_dl[15][0];
      res_c.point_y  = pt_dl[15][1];
      res_c.point_z  = pt_dl[15][2];
      res_c.normal_x = nval[0];
      res_c.normal_y = nval[1];
      res_c.normal_z = nval[2];
      res_c.bary_u   = u_dl[32];
      res_c.bary_v   = v_dl[32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res57 <= res_c;
      hit57 <= hit_dl[48];
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_v) begin
        m_tvalid <= 1'b1;
        skid_v   <= 1'b0;
      end else begin
        m_tvalid <= up_valid;
      end
    end else if (up_valid) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      if (skid_v) begin
        out_data <= skid_data;
        out_hit  <= skid_hit;
      end else if (up_valid) begin
        out_data <= res57;
        out_hit  <= hit57;
      end
    end else if (up_valid) begin
      skid_data <= res57;
      skid_hit  <= hit57;
    end
  end

  assign m_tdata = {7'd0, out_data};
  assign m_tuser = out_hit;

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("miss beat carries nonzero fields");

  a_skid_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> m_tvalid)
    else $error("skid holds a beat while output is empty");

  a_bary_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> ({1'b0, out_data.bary_u} + {1'b0, out_data.bary_v}) <= 18'd65536)
    else $error("barycentric weights exceed one");

endmodule
